FILE: hdl/pbrw_pkg.sv
// Package for the packet bit-field reader and writer.
// Holds the shared types, codes and a helper function; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pbrw_pkg;

  localparam int BUFFER_BYTES_DEF   = 256;
  localparam int MAX_FIELD_BITS_DEF = 32;
  localparam int FIELD_W            = 32;
  localparam int SPAN_W             = 40;
  localparam int CHK_W              = 16;
  localparam int PKT_BYTES_W        = 9;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic {
    REG_PACKET_BYTES = 1'b0,
    REG_BIT_ORDER    = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_XFER,
    ST_FINAL,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [PKT_BYTES_W-1:0] packet_bytes;
    logic                   bit_order;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         byte_index;
    logic [7:0]         byte_value;
    logic [10:0]        bit_offset;
    logic [5:0]         bit_length;
    logic               is_signed;
    logic [FIELD_W-1:0] field_value;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] field_out;
    logic               in_range;
  } result_t;

  function automatic logic [FIELD_W-1:0] field_mask(input logic [5:0] len);
    logic [FIELD_W:0] wide;
    wide = (33'd1 << len) - 33'd1;
    return wide[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pbrw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for the packet byte buffer.
`timescale 1ns / 1ps
`default_nettype none

module pbrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/pbrw_core.sv
// Sequencer that clears the byte buffer and walks the bytes of a field, reading
// one byte a cycle, merging it back for a write. Uses pbrw_pkg and pbrw_ram.
`timescale 1ns / 1ps
`default_nettype none

module pbrw_core #(
  parameter int BUFFER_BYTES   = pbrw_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = pbrw_pkg::MAX_FIELD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire  pbrw_pkg::cfg_t   cfg,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  pbrw_pkg::item_t  item,
  output pbrw_pkg::result_t      res,
  input  wire                    res_ready
);

  import pbrw_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  seq_state_t state, state_next;

  logic [AW-1:0]      clr_addr;
  item_t              item_r;
  logic [AW-1:0]      rd_addr;
  logic [2:0]         cnt;
  logic [2:0]         nbytes;
  logic [5:0]         shamt;
  logic [SPAN_W-1:0]  acc;
  logic [SPAN_W-1:0]  wmask;
  logic [SPAN_W-1:0]  wbits;
  logic [FIELD_W-1:0] mask_r;
  logic [FIELD_W-1:0] res_field;
  logic               res_ok;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  logic [CHK_W-1:0]   limit;
  logic [CHK_W-1:0]   span_end;
  logic               field_ok;
  logic               load_ok;
  logic [6:0]         fend;
  logic [2:0]         n_calc;
  logic [6:0]         sh_msb;
  logic [6:0]         sh_lsb;
  logic [FIELD_W-1:0] mask_calc;
  logic [SPAN_W-1:0]  wbits_calc;
  logic [SPAN_W-1:0]  wmask_calc;
  logic [6:0]         place;
  logic [7:0]         merged;
  logic [SPAN_W-1:0]  shifted;
  logic [FIELD_W-1:0] extracted;

  pbrw_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    limit = ({{(CHK_W-PKT_BYTES_W){1'b0}}, cfg.packet_bytes} < CHK_W'(BUFFER_BYTES)) ?
            {{(CHK_W-PKT_BYTES_W){1'b0}}, cfg.packet_bytes} : CHK_W'(BUFFER_BYTES);
    span_end = CHK_W'(item_r.bit_offset) + CHK_W'(item_r.bit_length);
    field_ok = (item_r.bit_length != 6'd0) &&
               (CHK_W'(item_r.bit_length) <= CHK_W'(MAX_FIELD_BITS)) &&
               (span_end <= (limit << 3));
    load_ok = CHK_W'(item_r.byte_index) < CHK_W'(BUFFER_BYTES);
    fend = 7'(item_r.bit_offset[2:0]) + 7'(item_r.bit_length);
    n_calc = 3'((fend + 7'd7) >> 3);
    sh_msb = {1'b0, n_calc, 3'b000} - fend;
    sh_lsb = 7'(SPAN_W) - {1'b0, n_calc, 3'b000} + 7'(item_r.bit_offset[2:0]);
    place = 7'(SPAN_W) - fend;
    mask_calc = field_mask(item_r.bit_length);
    wbits_calc = SPAN_W'(item_r.field_value & mask_calc) << place;
    wmask_calc = SPAN_W'(mask_calc) << place;
    merged = (ram_rdata & ~wmask[SPAN_W-1 -: 8]) | wbits[SPAN_W-1 -: 8];
    shifted = acc >> shamt;
    extracted = shifted[FIELD_W-1:0] & mask_r;
    if (item_r.is_signed && ((extracted & ~(mask_r >> 1)) != '0)) begin
      extracted = extracted | ~mask_r;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = rd_addr;
    ram_wdata  = merged;
    ram_raddr  = rd_addr + AW'(1);
    res.valid     = 1'b0;
    res.field_out = res_field;
    res.in_range  = res_ok;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 8'd0;
        if (clr_addr == AW'(BUFFER_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ram_raddr = AW'(item_r.bit_offset >> 3);
        if (item_r.kind == KIND_LOAD) begin
          ram_we     = load_ok;
          ram_waddr  = AW'(item_r.byte_index);
          ram_wdata  = item_r.byte_value;
          state_next = ST_DONE;
        end else if ((item_r.kind == KIND_READ || item_r.kind == KIND_WRITE) && field_ok) begin
          state_next = ST_XFER;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_XFER: begin
        ram_we = (item_r.kind == KIND_WRITE);
        if (cnt + 3'd1 == nbytes) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          item_r <= item;
        end
      end
      ST_CHECK: begin
        rd_addr   <= ram_raddr;
        cnt       <= 3'd0;
        nbytes    <= n_calc;
        shamt     <= cfg.bit_order ? sh_lsb[5:0] : sh_msb[5:0];
        mask_r    <= mask_calc;
        wmask     <= wmask_calc;
        wbits     <= wbits_calc;
        res_field <= '0;
        res_ok    <= (item_r.kind == KIND_LOAD) ? load_ok :
                     ((item_r.kind == KIND_READ || item_r.kind == KIND_WRITE) && field_ok);
      end
      ST_XFER: begin
        acc   <= cfg.bit_order ? {ram_rdata, acc[SPAN_W-1:8]} : {acc[SPAN_W-9:0], ram_rdata};
        wmask <= wmask << 8;
        wbits <= wbits << 8;
        cnt   <= cnt + 3'd1;
        rd_addr <= ram_raddr;
      end
      ST_FINAL: begin
        res_field <= (item_r.kind == KIND_READ) ? extracted : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/packet_bitfield_read_write_top.sv
// Packet bit-field reader and writer: top level with register file and output stage.
// Depends on pbrw_pkg and pbrw_core.
//
// Input beats arrive on the s_ stream. s_tuser carries the kind: load one byte,
// read a field or write a field. Each input beat yields exactly one output beat
// on the m_ stream with the extracted field in m_tdata and the in-range flag in
// m_tuser. Fields of 1 to 32 bits at any bit offset are handled one buffer byte
// per cycle through a single byte memory.
// Each item passes a check state; a byte load, a refused field or an unknown kind
// then goes to the done state, while a field spanning n buffer bytes (n is 1 to 5)
// first passes the transfer state, one byte a step, and a final state. Its output
// beat is registered from the done state.
// Results are held in an output register, so a finished beat waits there while
// the next item is taken; the core stalls only when that register is still full.
// The registers packet_bytes and bit_order are written through cfg_we, cfg_index and
// cfg_wdata; the user must do so only while idle, which the block does not enforce.
// A synchronous reset zeroes both registers and then sweeps the buffer to zero,
// one byte a cycle over all BUFFER_BYTES bytes, with s_tready low during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module packet_bitfield_read_write_top #(
  parameter int BUFFER_BYTES   = pbrw_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = pbrw_pkg::MAX_FIELD_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // byte_index, byte_value, bit_offset, bit_length, is_signed, field_value, zero fill
  input  wire  [71:0] s_tdata,
  // kind
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // field_out
  output logic [31:0] m_tdata,
  // in_range
  output logic        m_tuser,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [8:0]  cfg_wdata
);

  import pbrw_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PACKET_BYTES: cfg.packet_bytes <= cfg_wdata;
        REG_BIT_ORDER:    cfg.bit_order    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.kind        = s_tuser;
    item.byte_index  = s_tdata[7:0];
    item.byte_value  = s_tdata[15:8];
    item.bit_offset  = s_tdata[26:16];
    item.bit_length  = s_tdata[32:27];
    item.is_signed   = s_tdata[33];
    item.field_value = s_tdata[65:34];
  end

  pbrw_core #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .item     (item),
    .res      (res),
    .res_ready(res_take)
  );

  assign res_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      m_tdata <= res.field_out;
      m_tuser <= res.in_range;
    end
  end

`ifndef SYNTH
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res.valid && m_tvalid && !m_tready |=> res.valid)
    else $error("finished result dropped while output stage full");

  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken during buffer clearing sweep");

  a_refused_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("refused beat carries nonzero field");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/packet_bitfield_read_write_top_tb.sv
// Testbench for packet_bitfield_read_write_top: byte loads, field reads and field writes.
// It predicts each result beat from its own copy of the packet buffer and registers.
// It depends on pbrw_pkg and on the RTL of the block.
`timescale 1ns / 1ps

module packet_bitfield_read_write_top_tb;
  import pbrw_pkg::*;

  localparam int BUF_BYTES     = BUFFER_BYTES_DEF;
  localparam int MAX_BITS      = MAX_FIELD_BITS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    logic [31:0] field_out;
    logic        in_range;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  logic [7:0]  shadow_buf [0:BUF_BYTES-1];
  logic [8:0]  cfg_packet_bytes = '0;
  logic        cfg_lsb_first = 1'b0;

  item_t          pending_accesses[$];
  access_result_t expected_fields[$];

  int accesses_queued = 0;
  int accesses_taken  = 0;
  int results_checked = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int config_writes   = 0;
  int loads_done = 0, reads_done = 0, writes_done = 0, refused = 0;

  logic in_taken = 1'b0;
  int   src_gap = 0, src_calm = 0, sent_count = 0;
  bit   drain_hold = 1'b0;
  int   sink_stall = 0, sink_calm = 0;

  packet_bitfield_read_write_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    for (int i = 0; i < BUF_BYTES; i++) shadow_buf[i] = 8'h00;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Carries out one access on the shadow buffer and returns the beat it should produce.
  function automatic access_result_t apply_access(input item_t it);
    access_result_t res;
    int lim_bits;
    int len;
    int pos;
    logic [7:0] b8;
    res.field_out = '0;
    res.in_range = 1'b0;
    lim_bits = ((cfg_packet_bytes < BUF_BYTES) ? int'(cfg_packet_bytes) : BUF_BYTES) * 8;
    len = int'(it.bit_length);
    case (it.kind)
      KIND_LOAD: begin
        shadow_buf[it.byte_index] = it.byte_value;
        res.in_range = 1'b1;
      end
      KIND_READ, KIND_WRITE: begin
        if (len != 0 && len <= MAX_BITS && int'(it.bit_offset) + len <= lim_bits) begin
          res.in_range = 1'b1;
          for (int i = 0; i < len; i++) begin
            pos = int'(it.bit_offset) + i;
            if (it.kind == KIND_WRITE) begin
              shadow_buf[pos >> 3][7 - pos % 8] = it.field_value[len - 1 - i];
            end else begin
              b8 = shadow_buf[pos >> 3];
              if (cfg_lsb_first) res.field_out[i] = b8[pos % 8];
              else res.field_out = {res.field_out[30:0], b8[7 - pos % 8]};
            end
          end
          if (it.kind == KIND_READ && it.is_signed && len < 32 && res.field_out[len - 1])
            res.field_out = res.field_out | (32'hFFFF_FFFF << len);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic item_t make_load(input int idx, input int value);
    item_t it;
    it.kind        = KIND_LOAD;
    it.byte_index  = idx[7:0];
    it.byte_value  = value[7:0];
    it.bit_offset  = 11'($urandom);
    it.bit_length  = 6'($urandom);
    it.is_signed   = 1'($urandom);
    it.field_value = $urandom;
    return it;
  endfunction

  function automatic item_t make_field(input logic [1:0] kind, input int off, input int len,
                                       input bit sgn, input logic [31:0] value);
    item_t it;
    it.kind        = kind;
    it.byte_index  = 8'($urandom);
    it.byte_value  = 8'($urandom);
    it.bit_offset  = off[10:0];
    it.bit_length  = len[5:0];
    it.is_signed   = sgn;
    it.field_value = value;
    return it;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_access(input item_t it);
    pending_accesses = {pending_accesses, it};
    accesses_queued++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got %h, expected %h",
             what, results_checked, got, want);
    error_count++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [8:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PACKET_BYTES) cfg_packet_bytes = value;
    else cfg_lsb_first = value[0];
    config_writes++;
  endtask

  task automatic wait_quiet;
    while (accesses_taken != accesses_queued || expected_fields.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Source side: one item per beat, with random gaps and an occasional full drain.
  always @(negedge clk) begin
    item_t cur;
    if (!s_tvalid || in_taken) begin
      if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap--;
      end else if (drain_hold && expected_fields.size() != 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        cur = pending_accesses.pop_front();
        s_tdata  <= {6'd0, cur.field_value, cur.is_signed, cur.bit_length, cur.bit_offset,
                     cur.byte_value, cur.byte_index};
        s_tuser  <= cur.kind;
        s_tvalid <= 1'b1;
        drain_hold = (sent_count % 97 == 50) || ($urandom_range(0, 79) == 0);
        sent_count++;
        if (src_calm > 0) src_calm--;
        else if ($urandom_range(0, 99) == 0) src_calm = $urandom_range(20, 60);
        src_gap = pick_gap(src_calm > 0);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random stalls, mostly short, with calm stretches.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_tready <= 1'b1;
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 299) == 0) sink_calm = $urandom_range(30, 120);
      else if ($urandom_range(0, 2) == 0) sink_stall = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    access_result_t want;
    item_t seen;
    in_taken <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      seen.kind        = s_tuser;
      seen.byte_index  = s_tdata[7:0];
      seen.byte_value  = s_tdata[15:8];
      seen.bit_offset  = s_tdata[26:16];
      seen.bit_length  = s_tdata[32:27];
      seen.is_signed   = s_tdata[33];
      seen.field_value = s_tdata[65:34];
      want = apply_access(seen);
      expected_fields = {expected_fields, want};
      if (!want.in_range) refused++;
      else if (seen.kind == KIND_LOAD) loads_done++;
      else if (seen.kind == KIND_READ) reads_done++;
      else writes_done++;
      accesses_taken++;
    end
    if (m_tvalid && m_tready) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("beat with nothing outstanding", m_tdata, 32'd0);
      end else begin
        want = expected_fields.pop_front();
        if (m_tdata !== want.field_out) report_mismatch("field_out", m_tdata, want.field_out);
        if (m_tuser !== want.in_range)
          report_mismatch("in_range", {31'd0, m_tuser}, {31'd0, want.in_range});
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles: %0d of %0d items taken, %0d beats outstanding.",
               cycle_count, accesses_taken, accesses_queued, expected_fields.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    int r;
    int lim_bits;
    int win;
    int off;
    int len;
    logic [8:0] plen;
    logic       order;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (!s_tready) @(negedge clk);

    // Reset settings: an empty packet refuses every field, loads still land.
    queue_access(make_field(KIND_READ, 0, 8, 1'b0, 32'h0));
    queue_access(make_field(KIND_UNKNOWN, 2047, 63, 1'b1, 32'hFFFF_FFFF));
    queue_access(make_load(0, 8'hA5));
    queue_access(make_load(255, 8'hFF));
    wait_quiet;

    write_reg(REG_PACKET_BYTES, 9'd256);
    write_reg(REG_BIT_ORDER, 9'd0);
    queue_access(make_field(KIND_WRITE, 0, 32, 1'b0, 32'h8123_4567));
    queue_access(make_field(KIND_READ, 0, 32, 1'b1, 32'h0));
    queue_access(make_field(KIND_READ, 0, 4, 1'b1, 32'h0));
    queue_access(make_field(KIND_READ, 0, 1, 1'b1, 32'h0));
    queue_access(make_field(KIND_WRITE, 2016, 32, 1'b0, 32'hDEAD_BEEF));
    queue_access(make_field(KIND_READ, 2047, 1, 1'b0, 32'h0));
    queue_access(make_field(KIND_WRITE, 2017, 32, 1'b0, 32'h1234_5678));
    queue_access(make_field(KIND_READ, 2040, 0, 1'b0, 32'h0));
    queue_access(make_field(KIND_READ, 0, 33, 1'b0, 32'h0));
    queue_access(make_field(KIND_WRITE, 0, 63, 1'b1, 32'hFFFF_FFFF));
    queue_access(make_load(255, 8'h00));
    queue_access(make_field(KIND_WRITE, 13, 19, 1'b0, 32'hFFFF_FFFF));
    wait_quiet;

    write_reg(REG_BIT_ORDER, 9'd1);
    queue_access(make_field(KIND_READ, 3, 32, 1'b0, 32'h0));
    queue_access(make_field(KIND_READ, 13, 19, 1'b1, 32'h0));
    queue_access(make_field(KIND_READ, 2047, 1, 1'b1, 32'h0));
    wait_quiet;

    // A length register past the buffer size is clamped to the buffer.
    write_reg(REG_PACKET_BYTES, 9'd511);
    write_reg(REG_BIT_ORDER, 9'd0);
    queue_access(make_field(KIND_READ, 2016, 32, 1'b0, 32'h0));
    queue_access(make_field(KIND_READ, 2017, 32, 1'b0, 32'h0));
    wait_quiet;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin plen = 9'd256; order = 1'b0; end
        1: begin plen = 9'd256; order = 1'b1; end
        2: begin plen = 9'd511; order = 1'b0; end
        3: begin plen = 9'd0;   order = 1'b1; end
        4: begin plen = 9'($urandom_range(1, 255)); order = 1'($urandom); end
        5: begin plen = 9'd8;   order = 1'b0; end
        6: begin plen = 9'd300; order = 1'b1; end
        default: begin plen = 9'($urandom_range(1, 511)); order = 1'($urandom); end
      endcase
      write_reg(REG_PACKET_BYTES, plen);
      write_reg(REG_BIT_ORDER, {8'd0, order});
      lim_bits = ((plen < BUF_BYTES) ? int'(plen) : BUF_BYTES) * 8;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 28) begin
          queue_access(make_load($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 255),
                                 $urandom_range(0, 255)));
        end else if (r < 95) begin
          if ($urandom_range(0, 9) == 0)
            len = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
          else
            len = $urandom_range(1, 32);
          win = $urandom_range(0, 1) ? 256 : lim_bits;
          if (win > lim_bits) win = lim_bits;
          if ($urandom_range(0, 9) == 0 || win < len) off = $urandom_range(0, 2047);
          else off = $urandom_range(0, win - len);
          queue_access(make_field((r < 62) ? KIND_READ : KIND_WRITE, off, len,
                                  1'($urandom), $urandom));
        end else begin
          queue_access(make_field(KIND_UNKNOWN, $urandom_range(0, 2047),
                                  $urandom_range(0, 63), 1'($urandom), $urandom));
        end
      end
      wait_quiet;
    end

    $display("Checked %0d result beats over %0d register writes and %0d random settings.",
             results_checked, config_writes, PHASES);
    $display("Loads %0d, field reads %0d, field writes %0d, refused or ignored %0d.",
             loads_done, reads_done, writes_done, refused);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
